### hdl/kst_pkg.sv
// Shared types and codes for the keyed slot table.
package kst_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_ERASE   = 2'd1,
        REQ_REPLACE = 2'd2,
        REQ_UPDATE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        KIND_INSERTED  = 3'd0,
        KIND_ERASED    = 3'd1,
        KIND_DUPLICATE = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_LOADED    = 3'd5,
        KIND_NO_CHANGE = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_EV,
        S_PROBE_DONE,
        S_FR_ORD,
        S_FR_OEV,
        S_FR_IRD,
        S_FR_IEV,
        S_ER_ORD,
        S_ER_OEV,
        S_ER_IRD,
        S_ER_IEV,
        S_IN_RD,
        S_IN_EV,
        S_IN_SEEK,
        S_RP_RD,
        S_RP_EV,
        S_FLUSH
    } t_state;

endpackage

### hdl/kst_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module kst_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/keyed_slot_table_with_hole_reuse.sv
// Top level of the keyed slot table: sequencer, valid bits and result staging.
//
//  channel   | direction | handshake          | fields
//  ----------+-----------+--------------------+---------------------------------------------
//  request   | in        | i_start / o_busy   | req_type, entry_id, entry_payload, list_last
//  result    | out       | o_strobe           | result_kind, slot_index, result_id,
//            |           |                    | result_payload, result_last
//
// Every memory probe has an address step, then a compare on the registered read data.
// Insert and erase scan all slots. A replace or update element without the last mark is
// only staged. An update completion runs a freshness pass over the staged list, an erase
// pass over the valid slots and a placement pass of the fresh elements into free slots.
// A replace clears the table and loads the staged list into slots from zero.
// Reset is synchronous, active low, and empties the table and the staging buffer.
// Results are shown for one cycle on o_strobe; the receiver cannot stall them.
module keyed_slot_table_with_hole_reuse #(
    parameter int SLOT_COUNT    = 32,
    parameter int ID_WIDTH      = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_entry_id,
    input  logic [31:0] i_entry_payload,
    input  logic        i_list_last,
    output logic        o_strobe,
    output logic [2:0]  o_result_kind,
    output logic [4:0]  o_slot_index,
    output logic [31:0] o_result_id,
    output logic [31:0] o_result_payload,
    output logic        o_result_last
);
    import kst_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int DW = ID_WIDTH + PAYLOAD_WIDTH;
    localparam logic [CW-1:0] NSLOT = CW'(SLOT_COUNT);
    localparam logic [CW-1:0] ONE   = CW'(1);

    t_state r_state, n_state;

    logic [CW-1:0]            r_i, n_i, r_j, n_j, r_cnt, n_cnt, r_next, n_next;
    logic                     r_hit, n_hit, r_free, n_free;
    logic [IW-1:0]            r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [PAYLOAD_WIDTH-1:0] r_hit_pay, n_hit_pay;
    t_req                     r_op, n_op;
    logic [ID_WIDTH-1:0]      r_id, n_id, r_oid, n_oid;
    logic [PAYLOAD_WIDTH-1:0] r_pay, n_pay, r_opay, n_opay;
    logic [SLOT_COUNT-1:0]    r_valid, n_valid, r_fresh, n_fresh;

    logic                     r_pend, n_pend;
    t_kind                    r_pkind, n_pkind;
    logic [IW-1:0]            r_pidx, n_pidx;
    logic [ID_WIDTH-1:0]      r_pid, n_pid;
    logic [PAYLOAD_WIDTH-1:0] r_ppay, n_ppay;

    logic                     r_o_strobe, n_o_strobe, r_o_last, n_o_last;
    t_kind                    r_o_kind, n_o_kind;
    logic [IW-1:0]            r_o_idx, n_o_idx;
    logic [ID_WIDTH-1:0]      r_o_id, n_o_id;
    logic [PAYLOAD_WIDTH-1:0] r_o_pay, n_o_pay;

    logic          s_we, t_we;
    logic [IW-1:0] s_waddr, s_raddr, t_waddr, t_raddr;
    logic [DW-1:0] s_wdata, t_wdata, s_rdata, t_rdata;

    logic                     accept;
    logic [ID_WIDTH-1:0]      in_id, s_id, t_id;
    logic [PAYLOAD_WIDTH-1:0] in_pay, s_pay, t_pay;
    logic [IW-1:0]            i_ix, j_ix, next_ix;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign in_id   = ID_WIDTH'(i_entry_id);
    assign in_pay  = PAYLOAD_WIDTH'(i_entry_payload);
    assign s_id    = s_rdata[DW-1:PAYLOAD_WIDTH];
    assign s_pay   = s_rdata[PAYLOAD_WIDTH-1:0];
    assign t_id    = t_rdata[DW-1:PAYLOAD_WIDTH];
    assign t_pay   = t_rdata[PAYLOAD_WIDTH-1:0];
    assign i_ix    = r_i[IW-1:0];
    assign j_ix    = r_j[IW-1:0];
    assign next_ix = r_next[IW-1:0];

    kst_ram #(.DEPTH(SLOT_COUNT), .WIDTH(DW)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    kst_ram #(.DEPTH(SLOT_COUNT), .WIDTH(DW)) u_stage_ram (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(t_wdata),
        .i_raddr(t_raddr),
        .o_rdata(t_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_INSERT || i_req_type == REQ_ERASE) begin
                        n_state = S_PROBE_RD;
                    end else if (i_list_last) begin
                        n_state = (i_req_type == REQ_REPLACE) ? S_RP_RD : S_FR_ORD;
                    end
                end
            end
            S_PROBE_RD:   n_state = (r_i == NSLOT) ? S_PROBE_DONE : S_PROBE_EV;
            S_PROBE_EV:   n_state = S_PROBE_RD;
            S_PROBE_DONE: n_state = S_FLUSH;
            S_FR_ORD:     n_state = (r_i >= r_cnt) ? S_ER_ORD : S_FR_OEV;
            S_FR_OEV:     n_state = S_FR_IRD;
            S_FR_IRD:     n_state = (r_j == NSLOT) ? S_FR_ORD : S_FR_IEV;
            S_FR_IEV:     n_state = S_FR_IRD;
            S_ER_ORD:     n_state = (r_i == NSLOT) ? S_IN_RD : S_ER_OEV;
            S_ER_OEV:     n_state = r_valid[i_ix] ? S_ER_IRD : S_ER_ORD;
            S_ER_IRD:     n_state = (r_j >= r_cnt) ? S_ER_ORD : S_ER_IEV;
            S_ER_IEV:     n_state = S_ER_IRD;
            S_IN_RD: begin
                if (r_i >= r_cnt) begin
                    n_state = S_FLUSH;
                end else if (r_fresh[i_ix]) begin
                    n_state = S_IN_EV;
                end
            end
            S_IN_EV:      n_state = S_IN_SEEK;
            S_IN_SEEK: begin
                if (r_next == NSLOT || !r_valid[next_ix]) begin
                    n_state = S_IN_RD;
                end
            end
            S_RP_RD:      n_state = (r_i >= r_cnt) ? S_FLUSH : S_RP_EV;
            S_RP_EV:      n_state = S_RP_RD;
            S_FLUSH:      n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result words.
    always_comb begin
        logic                     e_do;
        t_kind                    e_kind;
        logic [IW-1:0]            e_idx;
        logic [ID_WIDTH-1:0]      e_id;
        logic [PAYLOAD_WIDTH-1:0] e_pay;

        e_do   = 1'b0;
        e_kind = KIND_NO_CHANGE;
        e_idx  = '0;
        e_id   = '0;
        e_pay  = '0;

        n_i = r_i;  n_j = r_j;  n_cnt = r_cnt;  n_next = r_next;
        n_hit = r_hit;  n_hit_idx = r_hit_idx;  n_hit_pay = r_hit_pay;
        n_free = r_free;  n_free_idx = r_free_idx;
        n_op = r_op;  n_id = r_id;  n_pay = r_pay;  n_oid = r_oid;  n_opay = r_opay;
        n_valid = r_valid;  n_fresh = r_fresh;
        n_pend = r_pend;  n_pkind = r_pkind;  n_pidx = r_pidx;
        n_pid = r_pid;  n_ppay = r_ppay;
        n_o_strobe = 1'b0;  n_o_last = r_o_last;  n_o_kind = r_o_kind;
        n_o_idx = r_o_idx;  n_o_id = r_o_id;  n_o_pay = r_o_pay;

        s_we = 1'b0;  s_waddr = i_ix;  s_wdata = {r_oid, r_opay};  s_raddr = i_ix;
        t_we = 1'b0;  t_waddr = r_cnt[IW-1:0];  t_wdata = {in_id, in_pay};  t_raddr = i_ix;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = t_req'(i_req_type);
                    n_id   = in_id;
                    n_pay  = in_pay;
                    n_i    = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    if (i_req_type == REQ_REPLACE || i_req_type == REQ_UPDATE) begin
                        if (r_cnt < NSLOT) begin
                            t_we  = 1'b1;
                            n_cnt = r_cnt + ONE;
                        end
                        if (i_list_last && i_req_type == REQ_REPLACE) begin
                            n_valid = '0;
                        end
                    end
                end
            end
            S_PROBE_RD: ;
            S_PROBE_EV: begin
                if (r_valid[i_ix] && s_id == r_id && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = i_ix;
                    n_hit_pay = s_pay;
                end
                if (!r_valid[i_ix] && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = i_ix;
                end
                n_i = r_i + ONE;
            end
            S_PROBE_DONE: begin
                e_do = 1'b1;
                e_id = r_id;
                if (r_op == REQ_INSERT) begin
                    if (r_hit) begin
                        e_kind = KIND_DUPLICATE;  e_idx = r_hit_idx;  e_pay = r_hit_pay;
                    end else if (r_free) begin
                        s_we    = 1'b1;
                        s_waddr = r_free_idx;
                        s_wdata = {r_id, r_pay};
                        n_valid[r_free_idx] = 1'b1;
                        e_kind = KIND_INSERTED;  e_idx = r_free_idx;  e_pay = r_pay;
                    end else begin
                        e_kind = KIND_FULL;  e_pay = r_pay;
                    end
                end else begin
                    if (r_hit) begin
                        n_valid[r_hit_idx] = 1'b0;
                        e_kind = KIND_ERASED;  e_idx = r_hit_idx;  e_pay = r_hit_pay;
                    end else begin
                        e_kind = KIND_NOT_FOUND;
                    end
                end
            end
            S_FR_ORD: begin
                if (r_i >= r_cnt) begin
                    n_i = '0;
                end
            end
            S_FR_OEV: begin
                n_oid = t_id;
                n_j   = '0;
                n_hit = 1'b0;
            end
            S_FR_IRD: begin
                s_raddr = j_ix;
                if (r_j == NSLOT) begin
                    n_fresh[i_ix] = !r_hit;
                    n_i = r_i + ONE;
                end
            end
            S_FR_IEV: begin
                if (r_valid[j_ix] && s_id == r_oid) begin
                    n_hit = 1'b1;
                end
                n_j = r_j + ONE;
            end
            S_ER_ORD: begin
                if (r_i == NSLOT) begin
                    n_i    = '0;
                    n_next = '0;
                end
            end
            S_ER_OEV: begin
                if (!r_valid[i_ix]) begin
                    n_i = r_i + ONE;
                end else begin
                    n_oid  = s_id;
                    n_opay = s_pay;
                    n_j    = '0;
                    n_hit  = 1'b0;
                end
            end
            S_ER_IRD: begin
                t_raddr = j_ix;
                if (r_j >= r_cnt) begin
                    if (!r_hit) begin
                        n_valid[i_ix] = 1'b0;
                        e_do = 1'b1;  e_kind = KIND_ERASED;  e_idx = i_ix;
                        e_id = r_oid;  e_pay = r_opay;
                    end
                    n_i = r_i + ONE;
                end
            end
            S_ER_IEV: begin
                if (t_id == r_oid) begin
                    n_hit = 1'b1;
                end
                n_j = r_j + ONE;
            end
            S_IN_RD: begin
                if (r_i < r_cnt && !r_fresh[i_ix]) begin
                    n_i = r_i + ONE;
                end
            end
            S_IN_EV: begin
                n_oid  = t_id;
                n_opay = t_pay;
            end
            S_IN_SEEK: begin
                e_id  = r_oid;
                e_pay = r_opay;
                if (r_next == NSLOT) begin
                    e_do = 1'b1;  e_kind = KIND_FULL;
                    n_i = r_i + ONE;
                end else if (r_valid[next_ix]) begin
                    n_next = r_next + ONE;
                end else begin
                    s_we    = 1'b1;
                    s_waddr = next_ix;
                    n_valid[next_ix] = 1'b1;
                    e_do = 1'b1;  e_kind = KIND_INSERTED;  e_idx = next_ix;
                    n_next = r_next + ONE;
                    n_i    = r_i + ONE;
                end
            end
            S_RP_RD: ;
            S_RP_EV: begin
                s_we    = 1'b1;
                s_waddr = i_ix;
                s_wdata = t_rdata;
                n_valid[i_ix] = 1'b1;
                e_do = 1'b1;  e_kind = KIND_LOADED;  e_idx = i_ix;
                e_id = t_id;  e_pay = t_pay;
                n_i = r_i + ONE;
            end
            S_FLUSH: begin
                // The held word becomes the last one; with none held the list changed nothing.
                n_o_strobe = 1'b1;
                n_o_last   = 1'b1;
                if (r_pend) begin
                    n_o_kind = r_pkind;  n_o_idx = r_pidx;
                    n_o_id   = r_pid;    n_o_pay = r_ppay;
                end else begin
                    n_o_kind = KIND_NO_CHANGE;  n_o_idx = '0;
                    n_o_id   = '0;              n_o_pay = '0;
                end
                n_pend = 1'b0;
                if (r_op == REQ_REPLACE || r_op == REQ_UPDATE) begin
                    n_cnt = '0;
                end
            end
            default: ;
        endcase

        // Each new word is held until the next one or the flush, so that the final one can carry the last mark.
        if (e_do) begin
            if (r_pend) begin
                n_o_strobe = 1'b1;
                n_o_last   = 1'b0;
                n_o_kind   = r_pkind;
                n_o_idx    = r_pidx;
                n_o_id     = r_pid;
                n_o_pay    = r_ppay;
            end
            n_pend  = 1'b1;
            n_pkind = e_kind;
            n_pidx  = e_idx;
            n_pid   = e_id;
            n_ppay  = e_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_valid    <= '0;
            r_pend     <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_valid    <= n_valid;
            r_pend     <= n_pend;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_j <= n_j;  r_next <= n_next;
        r_hit <= n_hit;  r_hit_idx <= n_hit_idx;  r_hit_pay <= n_hit_pay;
        r_free <= n_free;  r_free_idx <= n_free_idx;
        r_op <= n_op;  r_id <= n_id;  r_pay <= n_pay;  r_oid <= n_oid;  r_opay <= n_opay;
        r_fresh <= n_fresh;
        r_pkind <= n_pkind;  r_pidx <= n_pidx;  r_pid <= n_pid;  r_ppay <= n_ppay;
        r_o_last <= n_o_last;  r_o_kind <= n_o_kind;  r_o_idx <= n_o_idx;
        r_o_id <= n_o_id;  r_o_pay <= n_o_pay;
    end

    assign o_strobe         = r_o_strobe;
    assign o_result_kind    = r_o_kind;
    assign o_slot_index     = 5'(r_o_idx);
    assign o_result_id      = 32'(r_o_id);
    assign o_result_payload = 32'(r_o_pay);
    assign o_result_last    = r_o_last;
endmodule

### tb/sv/tb_keyed_slot_table_with_hole_reuse.sv
// Self-checking testbench for the keyed slot table with first-free slot reuse.
`timescale 1ns / 100ps

module tb_keyed_slot_table_with_hole_reuse;
    import kst_pkg::*;

    localparam int NSLOT = 32;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        t_req        req;
        logic [31:0] id;
        logic [31:0] payload;
        logic        last;
    } t_word;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  slot;
        logic [31:0] id;
        logic [31:0] payload;
        logic        last;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_entry_id = '0;
    logic [31:0] i_entry_payload = '0;
    logic        i_list_last = 1'b0;
    logic        o_strobe;
    logic [2:0]  o_result_kind;
    logic [4:0]  o_slot_index;
    logic [31:0] o_result_id;
    logic [31:0] o_result_payload;
    logic        o_result_last;

    keyed_slot_table_with_hole_reuse u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_entry_id(i_entry_id),
        .i_entry_payload(i_entry_payload), .i_list_last(i_list_last),
        .o_strobe(o_strobe), .o_result_kind(o_result_kind),
        .o_slot_index(o_slot_index), .o_result_id(o_result_id),
        .o_result_payload(o_result_payload), .o_result_last(o_result_last)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a mirror of the table and of the staged list.
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_id    [NSLOT];
    logic [31:0] tbl_pay   [NSLOT];
    logic [31:0] stg_id    [NSLOT];
    logic [31:0] stg_pay   [NSLOT];
    int          stg_count;

    t_word    pending_words[$];
    t_outcome expected_outcomes[$];
    int       error_count;
    int       idle_pct;
    bit       hold_off;
    bit       word_in_flight = 1'b0;
    int       quiet_cycles;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void push_outcome(t_kind k, int s, logic [31:0] id, logic [31:0] p);
        t_outcome o;
        o.kind = k; o.slot = s[4:0]; o.id = id; o.payload = p; o.last = 1'b0;
        expected_outcomes.push_back(o);
    endfunction

    function automatic bit in_table(logic [31:0] id);
        for (int s = 0; s < NSLOT; s++)
            if (tbl_valid[s] && tbl_id[s] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit in_list(logic [31:0] id);
        for (int k = 0; k < stg_count; k++)
            if (stg_id[k] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void predict_table(t_word w);
        int n_prior;
        int s;
        int nxt;
        bit fresh [NSLOT];
        t_outcome o;
        n_prior = expected_outcomes.size();
        if (w.req == REQ_INSERT || w.req == REQ_ERASE) begin
            for (s = 0; s < NSLOT; s++)
                if (tbl_valid[s] && tbl_id[s] == w.id) break;
            if (w.req == REQ_INSERT) begin
                if (s < NSLOT) begin
                    push_outcome(KIND_DUPLICATE, s, w.id, tbl_pay[s]);
                end else begin
                    for (s = 0; s < NSLOT && tbl_valid[s]; s++) ;
                    if (s < NSLOT) begin
                        tbl_valid[s] = 1'b1; tbl_id[s] = w.id; tbl_pay[s] = w.payload;
                        push_outcome(KIND_INSERTED, s, w.id, w.payload);
                    end else begin
                        push_outcome(KIND_FULL, 0, w.id, w.payload);
                    end
                end
            end else if (s < NSLOT) begin
                tbl_valid[s] = 1'b0;
                push_outcome(KIND_ERASED, s, w.id, tbl_pay[s]);
            end else begin
                push_outcome(KIND_NOT_FOUND, 0, w.id, 32'd0);
            end
        end else begin
            if (stg_count < NSLOT) begin
                stg_id[stg_count] = w.id; stg_pay[stg_count] = w.payload;
                stg_count++;
            end
            if (!w.last) return;
            if (w.req == REQ_REPLACE) begin
                for (s = 0; s < NSLOT; s++) tbl_valid[s] = 1'b0;
                for (s = 0; s < stg_count; s++) begin
                    tbl_valid[s] = 1'b1; tbl_id[s] = stg_id[s]; tbl_pay[s] = stg_pay[s];
                    push_outcome(KIND_LOADED, s, stg_id[s], stg_pay[s]);
                end
            end else begin
                for (int k = 0; k < stg_count; k++) fresh[k] = !in_table(stg_id[k]);
                for (s = 0; s < NSLOT; s++)
                    if (tbl_valid[s] && !in_list(tbl_id[s])) begin
                        tbl_valid[s] = 1'b0;
                        push_outcome(KIND_ERASED, s, tbl_id[s], tbl_pay[s]);
                    end
                nxt = 0;
                for (int k = 0; k < stg_count; k++) begin
                    if (!fresh[k]) continue;
                    while (nxt < NSLOT && tbl_valid[nxt]) nxt++;
                    if (nxt < NSLOT) begin
                        tbl_valid[nxt] = 1'b1; tbl_id[nxt] = stg_id[k];
                        tbl_pay[nxt] = stg_pay[k];
                        push_outcome(KIND_INSERTED, nxt, stg_id[k], stg_pay[k]);
                    end else begin
                        push_outcome(KIND_FULL, 0, stg_id[k], stg_pay[k]);
                    end
                end
            end
            if (expected_outcomes.size() == n_prior)
                push_outcome(KIND_NO_CHANGE, 0, 32'd0, 32'd0);
            stg_count = 0;
        end
        o = expected_outcomes[$];
        o.last = 1'b1;
        expected_outcomes[$] = o;
    endfunction

    function automatic t_word mk(t_req r, logic [31:0] id, logic [31:0] p, logic l);
        t_word w;
        w.req = r; w.id = id; w.payload = p; w.last = l;
        return w;
    endfunction

    // Ids come mostly from a small pool so that duplicates, hits and misses all occur.
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 19'd0, 5'($urandom_range(0, 23))};
    endfunction

    // Driver: one word is offered at a time; start drops only after acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_table(pending_words.pop_front());
            end
            if (!(i_start && o_busy)) begin
                if (!hold_off && pending_words.size() > 0 &&
                    $urandom_range(0, 99) >= idle_pct) begin
                    i_start         <= 1'b1;
                    i_req_type      <= pending_words[0].req;
                    i_entry_id      <= pending_words[0].id;
                    i_entry_payload <= pending_words[0].payload;
                    i_list_last     <= pending_words[0].last;
                    word_in_flight  <= 1'b1;
                end else begin
                    i_start        <= 1'b0;
                    word_in_flight <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_strobe) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_outcomes.pop_front();
                if (o_result_kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_result_kind, e.kind));
                if (o_slot_index !== e.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", o_slot_index, e.slot));
                if (o_result_id !== e.id)
                    report_mismatch($sformatf("id %h, want %h", o_result_id, e.id));
                if (o_result_payload !== e.payload)
                    report_mismatch($sformatf("payload %h, want %h", o_result_payload,
                                              e.payload));
                if (o_result_last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_result_last, e.last));
            end
        end
    end

    // Watchdog: counts cycles in which no word and no result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (i_start && !o_busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_keyed_slot_table_with_hole_reuse: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || word_in_flight || expected_outcomes.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        int n;
        int len;
        t_req r;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: pending_words.push_back(mk(REQ_INSERT, pick_id(), $urandom(),
                                                    1'($urandom)));
                3, 4:    pending_words.push_back(mk(REQ_ERASE, pick_id(), $urandom(),
                                                    1'($urandom)));
                default: begin
                    r = $urandom_range(0, 1) ? REQ_UPDATE : REQ_REPLACE;
                    len = $urandom_range(0, 9) == 0 ? $urandom_range(28, 34) : $urandom_range(1, 8);
                    for (int k = 0; k < len; k++) begin
                        pending_words.push_back(mk($urandom_range(0, 7) == 0 ?
                            ($urandom_range(0, 1) ? REQ_UPDATE : REQ_REPLACE) : r,
                            pick_id(), $urandom(), k == len - 1));
                    end
                    // An occasional element of the other list type is mixed into a list.
                    n += len - 1;
                end
            endcase
            n++;
        end
    endtask

    initial begin
        error_count = 0;
        idle_pct = 0;
        hold_off = 1'b0;
        stg_count = 0;
        for (int s = 0; s < NSLOT; s++) tbl_valid[s] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extremes, duplicate, hole reuse, full, lists.
        pending_words.push_back(mk(REQ_ERASE, 32'h0, 32'hFFFF_FFFF, 1'b1));
        pending_words.push_back(mk(REQ_INSERT, 32'h0, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        pending_words.push_back(mk(REQ_INSERT, 32'h5, 32'h1234, 1'b0));
        pending_words.push_back(mk(REQ_ERASE, 32'hFFFF_FFFF, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_INSERT, 32'h5, 32'h9999, 1'b0));
        pending_words.push_back(mk(REQ_INSERT, 32'h7, 32'hAAAA_5555, 1'b0));
        pending_words.push_back(mk(REQ_REPLACE, 32'h0, 32'h0, 1'b1));
        pending_words.push_back(mk(REQ_UPDATE, 32'h0, 32'h1, 1'b0));
        pending_words.push_back(mk(REQ_INSERT, 32'h42, 32'h42, 1'b0));
        pending_words.push_back(mk(REQ_UPDATE, 32'h9, 32'h2, 1'b0));
        pending_words.push_back(mk(REQ_UPDATE, 32'h9, 32'h3, 1'b1));
        pending_words.push_back(mk(REQ_UPDATE, 32'h0, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_UPDATE, 32'h9, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_UPDATE, 32'h42, 32'h0, 1'b1));
        for (int k = 0; k < 34; k++)
            pending_words.push_back(mk(REQ_REPLACE, 32'h100 + k, ~k, k == 33));
        pending_words.push_back(mk(REQ_INSERT, 32'h1, 32'h1, 1'b0));
        pending_words.push_back(mk(REQ_ERASE, 32'h10A, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_INSERT, 32'h1, 32'h1, 1'b0));
        pending_words.push_back(mk(REQ_UPDATE, 32'h100, 32'h0, 1'b0));
        pending_words.push_back(mk(REQ_REPLACE, 32'h77, 32'h7, 1'b1));
        wait_drained();

        idle_pct = 0;  queue_random(30); wait_drained();
        // Hold the sender off once the table has reported everything, then release it.
        hold_off = 1'b1; repeat (20) @(posedge i_clk); hold_off = 1'b0;
        idle_pct = 79; queue_random(30); wait_drained();
        idle_pct = 18; queue_random(30); wait_drained();
        idle_pct = 0;  queue_random(25); wait_drained();

        repeat (2200) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("tb_keyed_slot_table_with_hole_reuse: done, clean");
        end else begin
            $display("tb_keyed_slot_table_with_hole_reuse: done, errors");
        end
        $finish;
    end
endmodule
